// ===== hw/rtl/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared types and codes for the telecontrol command retry sequencer:
// request and result payloads, register map, command and status codes.
// ----------------------------------------------------------------------------
package tcr_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int LIMIT_W        = 8;
    localparam int TICKS_W        = 16;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;
    localparam int REG_IDX_W      = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_USER_ENABLE     = 3'd0,
        REG_RETRY_ON_LIMIT  = 3'd1,
        REG_RETRY_OFF_LIMIT = 3'd2,
        REG_TIMEOUT_TICKS   = 3'd3,
        REG_DELAY_TICKS     = 3'd4
    } reg_idx_t;

    localparam logic               USER_ENABLE_RST = 1'b0;
    localparam logic [LIMIT_W-1:0] RETRY_ON_RST    = 8'd3;
    localparam logic [LIMIT_W-1:0] RETRY_OFF_RST   = 8'd3;
    localparam logic [TICKS_W-1:0] TIMEOUT_RST     = 16'd10;
    localparam logic [TICKS_W-1:0] DELAY_RST       = 16'd5;

    localparam logic [LIMIT_W-1:0] ATTEMPT_MAX = {LIMIT_W{1'b1}};

    localparam logic       OP_POLL = 1'b0;
    localparam logic       OP_SET  = 1'b1;

    localparam logic [1:0] DRIVE_NONE = 2'd0;
    localparam logic [1:0] DRIVE_ON   = 2'd1;
    localparam logic [1:0] DRIVE_OFF  = 2'd2;

    localparam logic [2:0] ST_DONE_OFF   = 3'd0;
    localparam logic [2:0] ST_DONE_ON    = 3'd1;
    localparam logic [2:0] ST_USER_BLK   = 3'd2;
    localparam logic [2:0] ST_HW_BLK     = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd4;

    typedef struct packed {
        logic op;
        logic requested_value;
        logic set_value;
        logic confirm_present;
        logic confirm_state;
        logic permit_present;
        logic permit_state;
        logic tick;
    } poll_item_t;

    typedef struct packed {
        logic [1:0] drive_command;
        logic       status_valid;
        logic [2:0] status_code;
        logic       revert_valid;
        logic       revert_value;
    } result_item_t;

    typedef struct packed {
        logic               user_enable;
        logic [LIMIT_W-1:0] retry_on_limit;
        logic [LIMIT_W-1:0] retry_off_limit;
        logic [TICKS_W-1:0] timeout_ticks;
        logic [TICKS_W-1:0] delay_ticks;
    } cfg_t;

endpackage

// ===== hw/rtl/telecontrol_command_retry_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// telecontrol_command_retry_fsm_unit
// Remote switch command sequencer with confirmation timeout, pause and retry.
//
//   channel  | signals                                  | payload
//   ---------+------------------------------------------+---------------
//   poll     | poll_valid / poll_ready                  | poll_item_t
//   result   | result_valid / result_ready              | result_item_t
//   config   | psel penable pwrite paddr pwdata prdata  | 5 registers
//
// One request in, one result out; a request moves from the input register
// to the result register when the result register is free or being taken,
// so one request per cycle is sustained while result_ready stays high.
// A stalled result holds the result register; the input register still
// takes one more request behind it. Reset clears all sequencing state.
// ----------------------------------------------------------------------------
module telecontrol_command_retry_fsm_unit
    import tcr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               poll_valid,
    output logic               poll_ready,
    input  poll_item_t         poll_item,
    output logic               result_valid,
    input  logic               result_ready,
    output result_item_t       result_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t       cfg;
    poll_item_t item_reg;
    logic       item_valid_reg, item_valid_next;
    logic       out_valid_reg,  out_valid_next;
    logic       step;

    assign step            = item_valid_reg && (!out_valid_reg || result_ready);
    assign poll_ready      = !item_valid_reg || step;
    assign item_valid_next = (poll_valid && poll_ready) || (item_valid_reg && !step);
    assign out_valid_next  = step || (out_valid_reg && !result_ready);
    assign result_valid    = out_valid_reg;

    tcr_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcr_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && poll_ready)
        begin
            item_reg <= poll_item;
        end
    end

    a_revert_is_failure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.revert_valid |->
            result_item.status_valid && result_item.status_code == ST_EXHAUSTED)
        else $error("revert without retries exhausted status");

    a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_item.drive_command != 2'd3)
        else $error("undefined drive command");

    a_held_request: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !step |=> item_valid_reg && $stable(item_reg))
        else $error("pending request lost");

    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !$past(step) || !rst_n)
        else $error("result dropped after step");

endmodule

// ===== hw/rtl/tcr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tcr_cfg_regs
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module tcr_cfg_regs
    import tcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.user_enable     <= USER_ENABLE_RST;
            cfg_reg.retry_on_limit  <= RETRY_ON_RST;
            cfg_reg.retry_off_limit <= RETRY_OFF_RST;
            cfg_reg.timeout_ticks   <= TIMEOUT_RST;
            cfg_reg.delay_ticks     <= DELAY_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_USER_ENABLE:     cfg_reg.user_enable     <= pwdata[0];
                REG_RETRY_ON_LIMIT:  cfg_reg.retry_on_limit  <= pwdata[LIMIT_W-1:0];
                REG_RETRY_OFF_LIMIT: cfg_reg.retry_off_limit <= pwdata[LIMIT_W-1:0];
                REG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks   <= pwdata[TICKS_W-1:0];
                REG_DELAY_TICKS:     cfg_reg.delay_ticks     <= pwdata[TICKS_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_USER_ENABLE:     prdata = PDATA_W'(cfg_reg.user_enable);
            REG_RETRY_ON_LIMIT:  prdata = PDATA_W'(cfg_reg.retry_on_limit);
            REG_RETRY_OFF_LIMIT: prdata = PDATA_W'(cfg_reg.retry_off_limit);
            REG_TIMEOUT_TICKS:   prdata = PDATA_W'(cfg_reg.timeout_ticks);
            REG_DELAY_TICKS:     prdata = PDATA_W'(cfg_reg.delay_ticks);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/tcr_seq.sv =====
// ----------------------------------------------------------------------------
// tcr_seq
// Command sequencer: blocking checks, set values, issue, confirmation wait,
// timeout, pause and retry, with the result register loaded in the same step.
// ----------------------------------------------------------------------------
module tcr_seq
    import tcr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  poll_item_t   item,
    input  cfg_t         cfg,
    output result_item_t result
);

    localparam int CMP_W = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRY_ON    = 3'd1,
        PH_TRY_OFF   = 3'd2,
        PH_DELAY_ON  = 3'd3,
        PH_DELAY_OFF = 3'd4
    } phase_t;

    phase_t                phase_reg,   phase_next;
    logic                  last_reg,    last_next;
    logic [LIMIT_W-1:0]    attempt_reg, attempt_next;
    logic [TIMER_BITS-1:0] wait_reg,    wait_next;
    logic [TIMER_BITS-1:0] pause_reg,   pause_next;
    result_item_t          result_reg,  result_next;

    logic                  fb;
    logic                  permit;
    logic                  on_dir;
    logic [TIMER_BITS-1:0] wait_adv;
    logic [TIMER_BITS-1:0] pause_adv;
    logic                  wait_exp;
    logic                  pause_exp;
    logic [LIMIT_W-1:0]    attempt_inc;
    logic [LIMIT_W-1:0]    lim;

    assign fb          = item.confirm_present ? item.confirm_state : last_reg;
    assign permit      = item.permit_present ? item.permit_state : 1'b1;
    assign on_dir      = (phase_reg == PH_TRY_ON);
    assign wait_adv    = (item.tick && wait_reg != TMAX) ? wait_reg + TIMER_BITS'(1)
                                                         : wait_reg;
    assign pause_adv   = (item.tick && pause_reg != TMAX) ? pause_reg + TIMER_BITS'(1)
                                                          : pause_reg;
    assign wait_exp    = (CMP_W'(wait_adv) >= CMP_W'(cfg.timeout_ticks)) || (wait_adv == TMAX);
    assign pause_exp   = (CMP_W'(pause_adv) >= CMP_W'(cfg.delay_ticks)) || (pause_adv == TMAX);
    assign attempt_inc = (attempt_reg != ATTEMPT_MAX) ? attempt_reg + LIMIT_W'(1)
                                                      : attempt_reg;
    assign lim         = on_dir ? cfg.retry_on_limit : cfg.retry_off_limit;
    assign result      = result_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        last_next    = last_reg;
        attempt_next = attempt_reg;
        wait_next    = wait_reg;
        pause_next   = pause_reg;
        result_next  = '0;

        if (item.op == OP_SET)
        begin
            if (!item.confirm_present && last_reg != item.set_value)
            begin
                result_next.status_valid = 1'b1;
                result_next.status_code  = item.set_value ? ST_DONE_ON : ST_DONE_OFF;
                last_next                = item.set_value;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (last_reg != item.requested_value)
                    begin
                        if (!permit)
                        begin
                            result_next.status_valid = 1'b1;
                            result_next.status_code  = ST_HW_BLK;
                        end
                        else if (!cfg.user_enable)
                        begin
                            result_next.status_valid = 1'b1;
                            result_next.status_code  = ST_USER_BLK;
                        end
                        else
                        begin
                            last_next = item.requested_value;
                            wait_next = '0;
                            phase_next = item.requested_value ? PH_TRY_ON : PH_TRY_OFF;
                            result_next.drive_command =
                                item.requested_value ? DRIVE_ON : DRIVE_OFF;
                        end
                    end
                end
                PH_TRY_ON, PH_TRY_OFF:
                begin
                    if (fb == on_dir)
                    begin
                        last_next                = on_dir;
                        result_next.status_valid = 1'b1;
                        result_next.status_code  = on_dir ? ST_DONE_ON : ST_DONE_OFF;
                        attempt_next             = '0;
                        phase_next               = PH_IDLE;
                    end
                    else
                    begin
                        wait_next = wait_adv;
                        if (wait_exp)
                        begin
                            if (attempt_inc >= lim)
                            begin
                                result_next.revert_valid = 1'b1;
                                result_next.revert_value = last_reg;
                                result_next.status_valid = 1'b1;
                                result_next.status_code  = ST_EXHAUSTED;
                                attempt_next             = '0;
                                phase_next               = PH_IDLE;
                            end
                            else
                            begin
                                attempt_next = attempt_inc;
                                pause_next   = '0;
                                phase_next   = on_dir ? PH_DELAY_ON : PH_DELAY_OFF;
                            end
                        end
                    end
                end
                PH_DELAY_ON, PH_DELAY_OFF:
                begin
                    pause_next = pause_adv;
                    if (pause_exp)
                    begin
                        wait_next = '0;
                        if (phase_reg == PH_DELAY_ON)
                        begin
                            phase_next                = PH_TRY_ON;
                            result_next.drive_command = DRIVE_ON;
                        end
                        else
                        begin
                            phase_next                = PH_TRY_OFF;
                            result_next.drive_command = DRIVE_OFF;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            last_reg    <= 1'b0;
            attempt_reg <= '0;
            wait_reg    <= '0;
            pause_reg   <= '0;
            result_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            last_reg    <= last_next;
            attempt_reg <= attempt_next;
            wait_reg    <= wait_next;
            pause_reg   <= pause_next;
            result_reg  <= result_next;
        end
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the telecontrol command retry sequencer. Requests
// are queued by the stimulus thread and presented by a clocked driver. The
// monitor predicts every accepted request with its own sequencer model and
// compares each result against the oldest prediction, field by field.
// Directed requests cover blocking, set values, zero limits and retries.
// Random episodes follow under several register settings.
// ----------------------------------------------------------------------------
module tb import tcr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 7;
    localparam int LATENCY      = 1;
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [TIMER_BITS_DEF-1:0] TIMER_MAX = '1;

    typedef enum logic [2:0] {
        SEQ_IDLE      = 3'd0,
        SEQ_TRY_ON    = 3'd1,
        SEQ_TRY_OFF   = 3'd2,
        SEQ_DELAY_ON  = 3'd3,
        SEQ_DELAY_OFF = 3'd4
    } seq_phase_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               poll_valid = 1'b0;
    logic               poll_ready;
    poll_item_t         poll_item = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_item_t       result_item;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    poll_item_t   pending_requests[$];
    result_item_t expected_results[$];

    cfg_t                      cfg_mirror;
    seq_phase_t                sw_phase;
    logic                      sw_last;
    logic [LIMIT_W-1:0]        sw_attempts;
    logic [TIMER_BITS_DEF-1:0] sw_wait;
    logic [TIMER_BITS_DEF-1:0] sw_pause;

    int   errors = 0;
    int   cycles = 0;
    int   results_seen = 0;
    int   random_sent = 0;
    logic req_taken = 1'b0;
    logic steady = 1'b0;

    telecontrol_command_retry_fsm_unit uut (.*);

    always #5 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH result %0d: %s", results_seen, msg);
        errors++;
    endtask

    function automatic result_item_t predict_switch(poll_item_t it);
        result_item_t       r;
        logic               fb;
        logic               permit;
        logic               on;
        logic [LIMIT_W-1:0] lim;
        r = '0;
        fb = it.confirm_present ? it.confirm_state : sw_last;
        permit = it.permit_present ? it.permit_state : 1'b1;
        if (it.op == OP_SET) begin
            if (!it.confirm_present && sw_last != it.set_value) begin
                r.status_valid = 1'b1;
                r.status_code = it.set_value ? ST_DONE_ON : ST_DONE_OFF;
                sw_last = it.set_value;
            end
        end else begin
            case (sw_phase)
                SEQ_IDLE:
                begin
                    if (sw_last != it.requested_value) begin
                        if (!permit) begin
                            r.status_valid = 1'b1;
                            r.status_code = ST_HW_BLK;
                        end else if (!cfg_mirror.user_enable) begin
                            r.status_valid = 1'b1;
                            r.status_code = ST_USER_BLK;
                        end else begin
                            sw_last = it.requested_value;
                            sw_wait = '0;
                            sw_phase = it.requested_value ? SEQ_TRY_ON : SEQ_TRY_OFF;
                            r.drive_command = it.requested_value ? DRIVE_ON : DRIVE_OFF;
                        end
                    end
                end
                SEQ_TRY_ON, SEQ_TRY_OFF:
                begin
                    on = (sw_phase == SEQ_TRY_ON);
                    if (fb == on) begin
                        sw_last = on;
                        r.status_valid = 1'b1;
                        r.status_code = on ? ST_DONE_ON : ST_DONE_OFF;
                        sw_attempts = '0;
                        sw_phase = SEQ_IDLE;
                    end else begin
                        if (it.tick && sw_wait != TIMER_MAX)
                            sw_wait = sw_wait + 1'b1;
                        if (sw_wait >= cfg_mirror.timeout_ticks || sw_wait == TIMER_MAX) begin
                            lim = on ? cfg_mirror.retry_on_limit : cfg_mirror.retry_off_limit;
                            if (sw_attempts != ATTEMPT_MAX)
                                sw_attempts = sw_attempts + 1'b1;
                            if (sw_attempts >= lim) begin
                                r.revert_valid = 1'b1;
                                r.revert_value = sw_last;
                                r.status_valid = 1'b1;
                                r.status_code = ST_EXHAUSTED;
                                sw_attempts = '0;
                                sw_phase = SEQ_IDLE;
                            end else begin
                                sw_pause = '0;
                                sw_phase = on ? SEQ_DELAY_ON : SEQ_DELAY_OFF;
                            end
                        end
                    end
                end
                SEQ_DELAY_ON, SEQ_DELAY_OFF:
                begin
                    if (it.tick && sw_pause != TIMER_MAX)
                        sw_pause = sw_pause + 1'b1;
                    if (sw_pause >= cfg_mirror.delay_ticks || sw_pause == TIMER_MAX) begin
                        sw_wait = '0;
                        if (sw_phase == SEQ_DELAY_ON) begin
                            sw_phase = SEQ_TRY_ON;
                            r.drive_command = DRIVE_ON;
                        end else begin
                            sw_phase = SEQ_TRY_OFF;
                            r.drive_command = DRIVE_OFF;
                        end
                    end
                end
                default:
                begin
                    sw_phase = SEQ_IDLE;
                end
            endcase
        end
        return r;
    endfunction

    // Present the next request, hold an unaccepted one, idle at random.
    always @(negedge clk)
    begin
        result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (!poll_valid || req_taken) begin
            if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                poll_item <= pending_requests.pop_front();
                poll_valid <= 1'b1;
            end else begin
                poll_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        result_item_t want;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end else if (rst_n) begin
            req_taken <= poll_valid && poll_ready;
            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", result_item));
                end else begin
                    want = expected_results.pop_front();
                    if (result_item.drive_command !== want.drive_command)
                        report_mismatch($sformatf("drive_command %0d, want %0d",
                            result_item.drive_command, want.drive_command));
                    if (result_item.status_valid !== want.status_valid)
                        report_mismatch($sformatf("status_valid %0d, want %0d",
                            result_item.status_valid, want.status_valid));
                    if (result_item.status_code !== want.status_code)
                        report_mismatch($sformatf("status_code %0d, want %0d",
                            result_item.status_code, want.status_code));
                    if (result_item.revert_valid !== want.revert_valid)
                        report_mismatch($sformatf("revert_valid %0d, want %0d",
                            result_item.revert_valid, want.revert_valid));
                    if (result_item.revert_value !== want.revert_value)
                        report_mismatch($sformatf("revert_value %0d, want %0d",
                            result_item.revert_value, want.revert_value));
                end
                results_seen++;
            end
            if (poll_valid && poll_ready)
                expected_results.push_back(predict_switch(poll_item));
        end
    end

    function automatic poll_item_t mk_req(logic op, logic req, logic setv, logic cp,
                                          logic cs, logic pp, logic ps, logic tk);
        poll_item_t it;
        it = '{op, req, setv, cp, cs, pp, ps, tk};
        return it;
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return LIMIT_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [TICKS_W-1:0] pick_ticks();
        case ($urandom_range(9))
            0: return '0;
            1: return TICKS_W'($urandom_range(100, 65535));
            default: return TICKS_W'($urandom_range(0, 6));
        endcase
    endfunction

    task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_USER_ENABLE:     cfg_mirror.user_enable = data[0];
            REG_RETRY_ON_LIMIT:  cfg_mirror.retry_on_limit = data[LIMIT_W-1:0];
            REG_RETRY_OFF_LIMIT: cfg_mirror.retry_off_limit = data[LIMIT_W-1:0];
            REG_TIMEOUT_TICKS:   cfg_mirror.timeout_ticks = data[TICKS_W-1:0];
            REG_DELAY_TICKS:     cfg_mirror.delay_ticks = data[TICKS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_config(logic ue, logic [LIMIT_W-1:0] on_lim,
                                  logic [LIMIT_W-1:0] off_lim,
                                  logic [TICKS_W-1:0] tmo, logic [TICKS_W-1:0] dly);
        apb_write(REG_USER_ENABLE, PDATA_W'(ue));
        apb_write(REG_RETRY_ON_LIMIT, PDATA_W'(on_lim));
        apb_write(REG_RETRY_OFF_LIMIT, PDATA_W'(off_lim));
        apb_write(REG_TIMEOUT_TICKS, PDATA_W'(tmo));
        apb_write(REG_DELAY_TICKS, PDATA_W'(dly));
        @(posedge clk);
    endtask

    // Wait for every queued request to be answered.
    task automatic drain();
        while (pending_requests.size() != 0 || poll_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // One switching attempt: steady request, confirmation arriving at a random point or never.
    task automatic add_episode();
        poll_item_t it;
        int         len;
        int         confirm_at;
        int         k;
        logic       want;
        logic       cp;
        logic       noisy;
        len = $urandom_range(3, 24);
        want = 1'($urandom_range(1));
        cp = ($urandom_range(9) < 8);
        noisy = ($urandom_range(9) == 0);
        confirm_at = ($urandom_range(9) < 3) ? len : $urandom_range(len - 1);
        for (k = 0; k < len; k++) begin
            if (noisy || $urandom_range(19) == 0) begin
                it = poll_item_t'(8'($urandom));
            end else begin
                it.op = ($urandom_range(19) == 0) ? OP_SET : OP_POLL;
                it.requested_value = want;
                it.set_value = 1'($urandom_range(1));
                it.confirm_present = ($urandom_range(19) == 0) ? ~cp : cp;
                it.confirm_state = (k >= confirm_at) ? want : ~want;
                it.permit_present = ($urandom_range(3) == 0);
                it.permit_state = ($urandom_range(9) != 0);
                it.tick = ($urandom_range(9) < 7);
            end
            pending_requests.push_back(it);
            random_sent++;
        end
    endtask

    initial
    begin : stimulus
        int phase_no;
        int target;
        cfg_mirror = '{USER_ENABLE_RST, RETRY_ON_RST, RETRY_OFF_RST, TIMEOUT_RST, DELAY_RST};
        sw_phase = SEQ_IDLE;
        sw_last = 1'b0;
        sw_attempts = '0;
        sw_wait = '0;
        sw_pause = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Commands disabled: blocking and set values.
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 0, 0, 1, 0, 0));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 1, 1, 1, 1, 1));
        pending_requests.push_back(mk_req(OP_SET,  0, 1, 0, 0, 0, 0, 1));
        pending_requests.push_back(mk_req(OP_SET,  0, 1, 0, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_SET,  0, 0, 1, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 0, 0, 0, 0, 0));
        drain();

        // Zero limits and zero timers.
        program_config(1'b1, '0, '0, '0, '0);
        pending_requests.push_back(mk_req(OP_POLL, 0, 0, 1, 1, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_POLL, 0, 0, 1, 1, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 0, 0, 0, 0, 0));
        drain();

        // Retry, pause and reissue when switching on; exhaustion in both directions.
        program_config(1'b1, 8'd2, 8'd1, 16'd1, 16'd1);
        pending_requests.push_back(mk_req(OP_POLL, 0, 0, 1, 1, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_POLL, 0, 0, 1, 1, 0, 0, 1));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 1, 0, 1, 1, 0));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 1, 0, 0, 0, 1));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 1, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 1, 0, 0, 0, 1));
        pending_requests.push_back(mk_req(OP_POLL, 1, 0, 1, 0, 0, 0, 1));
        pending_requests.push_back(mk_req(OP_POLL, 0, 0, 1, 1, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_SET,  0, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_POLL, 0, 0, 0, 0, 0, 0, 1));
        drain();

        program_config(1'b1, '1, '1, '1, '1);
        target = random_sent + 60;
        while (random_sent < target)
            add_episode();

        phase_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain();
            program_config($urandom_range(9) != 0, pick_limit(), pick_limit(),
                           pick_ticks(), pick_ticks());
            steady = (phase_no == 3);
            target = random_sent + $urandom_range(60, 120);
            while (random_sent < target)
                add_episode();
            phase_no++;
        end

        drain();
        if (errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
